// ===== design/tan_pkg.sv =====
// tan_pkg: shared output widths and limits for the triangle area / normal block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tan_pkg;
  localparam int AREA_W = 37;
  localparam int NORM_W = 16;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam int NORM_MAX = 32767;
  localparam int NORM_MIN = -32768;
endpackage
`default_nettype wire

// ===== design/tan_front.sv =====
// tan_front: edge vectors, cross product, squared components and their sum
// seven register stages; no package use
`timescale 1ns / 1ps
`default_nettype none
module tan_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_in,
  input  wire logic [COORD_WIDTH-1:0] v0_x,
  input  wire logic [COORD_WIDTH-1:0] v0_y,
  input  wire logic [COORD_WIDTH-1:0] v0_z,
  input  wire logic [COORD_WIDTH-1:0] v1_x,
  input  wire logic [COORD_WIDTH-1:0] v1_y,
  input  wire logic [COORD_WIDTH-1:0] v1_z,
  input  wire logic [COORD_WIDTH-1:0] v2_x,
  input  wire logic [COORD_WIDTH-1:0] v2_y,
  input  wire logic [COORD_WIDTH-1:0] v2_z,
  output logic valid_out,
  output logic [2*(2*(COORD_WIDTH+1)+1)-1:0] sq [3],
  output logic [2*(2*(COORD_WIDTH+1)+1)+1:0] msum,
  output logic [2:0] sgn,
  output logic degen
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int MAGW = NW;
  localparam int LO = (MAGW + 1) / 2;
  localparam int HI = MAGW - LO;
  localparam int SQW = 2 * MAGW;
  localparam int MW = SQW + 2;

  logic [6:0] vld;
  logic signed [DW-1:0] ex, ey, ez, fx, fy, fz;
  logic signed [PW-1:0] p [6];
  logic signed [NW-1:0] n [3];
  logic [MAGW-1:0] mag [3];
  logic [2*HI-1:0] hh [3];
  logic [HI+LO-1:0] hl [3];
  logic [2*LO-1:0] ll [3];
  logic [SQW-1:0] sq6 [3];
  logic [2:0] sgn4, sgn5, sgn6;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], valid_in};
    end
  end
  assign valid_out = vld[6];

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    ex <= DW'($signed(v1_x)) - DW'($signed(v0_x));
    ey <= DW'($signed(v1_y)) - DW'($signed(v0_y));
    ez <= DW'($signed(v1_z)) - DW'($signed(v0_z));
    fx <= DW'($signed(v2_x)) - DW'($signed(v1_x));
    fy <= DW'($signed(v2_y)) - DW'($signed(v1_y));
    fz <= DW'($signed(v2_z)) - DW'($signed(v1_z));
  end

  // stage 2: cross product terms
  always_ff @(posedge clk) begin
    p[0] <= ey * fz;
    p[1] <= ez * fy;
    p[2] <= ez * fx;
    p[3] <= ex * fz;
    p[4] <= ex * fy;
    p[5] <= ey * fx;
  end

  // stage 3: cross product
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n[i] <= NW'(p[2*i]) - NW'(p[2*i+1]);
    end
  end

  // stage 4: magnitude and sign
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag[i] <= n[i][NW-1] ? MAGW'(~n[i] + 1'b1) : MAGW'(n[i]);
      sgn4[i] <= n[i][NW-1];
    end
  end

  // stage 5: partial products of the squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh[i] <= mag[i][MAGW-1:LO] * mag[i][MAGW-1:LO];
      hl[i] <= mag[i][MAGW-1:LO] * mag[i][LO-1:0];
      ll[i] <= mag[i][LO-1:0] * mag[i][LO-1:0];
    end
    sgn5 <= sgn4;
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= (SQW'(hh[i]) << (2 * LO)) + (SQW'(hl[i]) << (LO + 1)) + SQW'(ll[i]);
    end
    sgn6 <= sgn5;
  end

  // stage 7: squared length of the normal
  always_ff @(posedge clk) begin
    msum <= MW'(sq6[0]) + MW'(sq6[1]) + MW'(sq6[2]);
    degen <= (sq6[0] == '0) && (sq6[1] == '0) && (sq6[2] == '0);
    for (int i = 0; i < 3; i++) begin
      sq[i] <= sq6[i];
    end
    sgn <= sgn6;
  end
endmodule
`default_nettype wire

// ===== design/tan_div_cell.sv =====
// tan_div_cell: one restoring division step, one quotient bit per cell
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tan_div_cell #(
  parameter int DVW = 72,
  parameter int QW = 31,
  parameter bit FIRST = 1'b0
) (
  input  wire logic clk,
  input  wire logic [DVW:0] rem_in,
  input  wire logic [DVW-1:0] d_in,
  input  wire logic [QW-1:0] q_in,
  output logic [DVW:0] rem_out,
  output logic [DVW-1:0] d_out,
  output logic [QW-1:0] q_out
);
  logic [DVW:0] sh;
  logic ge;

  // shift in a zero, except on the leading bit
  always_comb begin
    sh = FIRST ? rem_in : {rem_in[DVW-1:0], 1'b0};
    ge = sh >= {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    rem_out <= ge ? sh - {1'b0, d_in} : sh;
    d_out <= d_in;
    q_out <= {q_in[QW-2:0], ge};
  end
endmodule
`default_nettype wire

// ===== design/tan_sqrt_cell.sv =====
// tan_sqrt_cell: one restoring square root step, one root bit per cell
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tan_sqrt_cell #(
  parameter int OW = 16
) (
  input  wire logic clk,
  input  wire logic [2*OW-1:0] val_in,
  input  wire logic [OW+1:0] rem_in,
  input  wire logic [OW-1:0] root_in,
  output logic [2*OW-1:0] val_out,
  output logic [OW+1:0] rem_out,
  output logic [OW-1:0] root_out
);
  logic [OW+1:0] rsh, trial;
  logic ge;

  // bring down two bits and try the next root bit
  always_comb begin
    rsh = {rem_in[OW-1:0], val_in[2*OW-1:2*OW-2]};
    trial = {root_in, 2'b01};
    ge = rsh >= trial;
  end

  always_ff @(posedge clk) begin
    rem_out <= ge ? rsh - trial : rsh;
    root_out <= {root_in[OW-2:0], ge};
    val_out <= {val_in[2*OW-3:0], 2'b00};
  end
endmodule
`default_nettype wire

// ===== design/triangle_area_and_unit_normal_top.sv =====
// triangle_area_and_unit_normal_top: four times triangle area and unit normal
// uses tan_pkg, tan_front, tan_div_cell, tan_sqrt_cell
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Drive the nine vertex coordinates and raise start; the item is taken at
//   each rising edge with start high and busy low. busy stays low, so one
//   triangle may enter in every cycle.
//   Each result appears for one cycle with done high: area_times_four is
//   floor(sqrt(4*|e x f|^2)), the normal is e x f scaled to unit length
//   with NORMAL_FRAC_BITS fraction bits, rounded half away from zero.
//   degenerate flags a zero-length normal; all other fields are then zero.
// Pipeline: 7 front stages, then L = max(2*COORD_WIDTH+5, 3*NORMAL_FRAC_BITS+5)
//   cells, then one output register.
//   The longer of two cell chains sets L: the area square root (one bit per
//   cell) or the normal path, a restoring divider with one quotient bit per
//   cell followed by a square root chain.
// Throughput: one item per cycle.
// Reset clears only the valid pipeline; results in flight are dropped.
// The receiver cannot stall; results are never held.
module triangle_area_and_unit_normal_top #(
  parameter int COORD_WIDTH = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [COORD_WIDTH-1:0] v0_x,
  input  wire logic [COORD_WIDTH-1:0] v0_y,
  input  wire logic [COORD_WIDTH-1:0] v0_z,
  input  wire logic [COORD_WIDTH-1:0] v1_x,
  input  wire logic [COORD_WIDTH-1:0] v1_y,
  input  wire logic [COORD_WIDTH-1:0] v1_z,
  input  wire logic [COORD_WIDTH-1:0] v2_x,
  input  wire logic [COORD_WIDTH-1:0] v2_y,
  input  wire logic [COORD_WIDTH-1:0] v2_z,
  output logic done,
  output logic [tan_pkg::AREA_W-1:0] area_times_four,
  output logic signed [tan_pkg::NORM_W-1:0] normal_x,
  output logic signed [tan_pkg::NORM_W-1:0] normal_y,
  output logic signed [tan_pkg::NORM_W-1:0] normal_z,
  output logic degenerate
);
  localparam int MAGW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int SQW = 2 * MAGW;
  localparam int MW = SQW + 2;
  localparam int HW = MW + 2;
  localparam int AW = HW / 2;
  localparam int QB = 2 * NORMAL_FRAC_BITS + 3;
  localparam int KB = NORMAL_FRAC_BITS + 2;
  localparam int NB = QB + KB;
  localparam int L = (AW > NB) ? AW : NB;
  localparam int ADLY = L - AW;
  localparam int NDLY = L - NB;
  localparam int AXW = (AW > tan_pkg::AREA_W) ? AW : tan_pkg::AREA_W;
  localparam int XW = (KB + 1 > tan_pkg::NORM_W + 1) ? KB + 1 : tan_pkg::NORM_W + 1;

  logic f_valid;
  logic [SQW-1:0] f_sq [3];
  logic [MW-1:0] f_m;
  logic [2:0] f_sgn;
  logic f_degen;

  assign busy = 1'b0;

  tan_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .valid_in(start && !busy),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .valid_out(f_valid), .sq(f_sq), .msum(f_m), .sgn(f_sgn), .degen(f_degen)
  );

  // area square root chain
  logic [HW-1:0] a_val [AW+1];
  logic [AW+1:0] a_rem [AW+1];
  logic [AW-1:0] a_root [AW+1];
  assign a_val[0] = {f_m, 2'b00};
  assign a_rem[0] = '0;
  assign a_root[0] = '0;
  for (genvar i = 0; i < AW; i++) begin : g_area
    tan_sqrt_cell #(.OW(AW)) u_cell (
      .clk(clk), .val_in(a_val[i]), .rem_in(a_rem[i]), .root_in(a_root[i]),
      .val_out(a_val[i+1]), .rem_out(a_rem[i+1]), .root_out(a_root[i+1])
    );
  end

  // area alignment
  logic [AW-1:0] a_dly [ADLY+1];
  assign a_dly[0] = a_root[AW];
  for (genvar i = 0; i < ADLY; i++) begin : g_adly
    always_ff @(posedge clk) begin
      a_dly[i+1] <= a_dly[i];
    end
  end

  // normal lanes: divider chain then square root chain
  logic [KB-1:0] k_dly [3][NDLY+1];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [MW:0] d_rem [QB+1];
    logic [MW-1:0] d_div [QB+1];
    logic [QB-1:0] d_q [QB+1];
    logic [2*KB-1:0] s_val [KB+1];
    logic [KB+1:0] s_rem [KB+1];
    logic [KB-1:0] s_root [KB+1];

    assign d_rem[0] = (MW + 1)'(f_sq[c]);
    assign d_div[0] = f_m;
    assign d_q[0] = '0;
    for (genvar i = 0; i < QB; i++) begin : g_div
      tan_div_cell #(.DVW(MW), .QW(QB), .FIRST(i == 0)) u_cell (
        .clk(clk), .rem_in(d_rem[i]), .d_in(d_div[i]), .q_in(d_q[i]),
        .rem_out(d_rem[i+1]), .d_out(d_div[i+1]), .q_out(d_q[i+1])
      );
    end

    assign s_val[0] = (2 * KB)'(d_q[QB]);
    assign s_rem[0] = '0;
    assign s_root[0] = '0;
    for (genvar i = 0; i < KB; i++) begin : g_sqrt
      tan_sqrt_cell #(.OW(KB)) u_cell (
        .clk(clk), .val_in(s_val[i]), .rem_in(s_rem[i]), .root_in(s_root[i]),
        .val_out(s_val[i+1]), .rem_out(s_rem[i+1]), .root_out(s_root[i+1])
      );
    end

    assign k_dly[c][0] = s_root[KB];
    for (genvar i = 0; i < NDLY; i++) begin : g_ndly
      always_ff @(posedge clk) begin
        k_dly[c][i+1] <= k_dly[c][i];
      end
    end
  end

  // sideband and valid alignment
  logic [L:1] v_dly;
  logic [3:0] sb_dly [L+1];
  assign sb_dly[0] = {f_degen, f_sgn};
  always_ff @(posedge clk) begin
    if (rst) begin
      v_dly <= '0;
    end else begin
      v_dly <= {v_dly[L-1:1], f_valid};
    end
  end
  for (genvar i = 0; i < L; i++) begin : g_sb
    always_ff @(posedge clk) begin
      sb_dly[i+1] <= sb_dly[i];
    end
  end

  // rounding, sign and saturation
  logic [AXW-1:0] area_ext;
  logic [tan_pkg::AREA_W-1:0] area_next;
  logic [KB:0] kp1 [3];
  logic signed [XW-1:0] sv [3];
  logic signed [tan_pkg::NORM_W-1:0] nrm_next [3];
  logic degen_l;
  always_comb begin
    degen_l = sb_dly[L][3];
    area_ext = AXW'(a_dly[ADLY]);
    if (degen_l) begin
      area_next = '0;
    end else if (area_ext > AXW'(tan_pkg::AREA_MAX)) begin
      area_next = tan_pkg::AREA_MAX;
    end else begin
      area_next = area_ext[tan_pkg::AREA_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      kp1[c] = {1'b0, k_dly[c][NDLY]} + 1'b1;
      sv[c] = sb_dly[L][c] ? -$signed(XW'(kp1[c][KB:1])) : $signed(XW'(kp1[c][KB:1]));
      if (degen_l) begin
        nrm_next[c] = '0;
      end else if (sv[c] > XW'(tan_pkg::NORM_MAX)) begin
        nrm_next[c] = tan_pkg::NORM_W'(tan_pkg::NORM_MAX);
      end else if (sv[c] < XW'(tan_pkg::NORM_MIN)) begin
        nrm_next[c] = tan_pkg::NORM_W'(tan_pkg::NORM_MIN);
      end else begin
        nrm_next[c] = sv[c][tan_pkg::NORM_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_dly[L];
    end
  end
  always_ff @(posedge clk) begin
    area_times_four <= area_next;
    normal_x <= nrm_next[0];
    normal_y <= nrm_next[1];
    normal_z <= nrm_next[2];
    degenerate <= degen_l;
  end
endmodule
`default_nettype wire

// ===== dv/triangle_area_and_unit_normal_top_tb.sv =====
// triangle_area_and_unit_normal_top_tb: self-checking bench for the area / unit normal block
// depends on tan_pkg and triangle_area_and_unit_normal_top
`timescale 1ns / 1ps
module triangle_area_and_unit_normal_top_tb;
  localparam int CW = 16;
  localparam int FB = 14;
  localparam int N_RANDOM = 680;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  typedef logic [8:0][CW-1:0] tri_t;
  typedef struct packed {
    logic [tan_pkg::AREA_W-1:0] area;
    logic signed [tan_pkg::NORM_W-1:0] nx;
    logic signed [tan_pkg::NORM_W-1:0] ny;
    logic signed [tan_pkg::NORM_W-1:0] nz;
    logic degen;
  } tri_res_t;
  typedef struct {
    tri_t corners;
    bit typed;
    tri_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate;
  logic [CW-1:0] v0_x = '0, v0_y = '0, v0_z = '0;
  logic [CW-1:0] v1_x = '0, v1_y = '0, v1_z = '0;
  logic [CW-1:0] v2_x = '0, v2_y = '0, v2_z = '0;
  logic [tan_pkg::AREA_W-1:0] area_times_four;
  logic signed [tan_pkg::NORM_W-1:0] normal_x, normal_y, normal_z;

  tri_res_t pending_res[$];
  int accepted_cnt = 0;
  int cycle_cnt = 0;
  bit failed = 0;
  stim_row_t rows[$];

  triangle_area_and_unit_normal_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .done(done), .area_times_four(area_times_four),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  // round(|x| * 2^FB / sqrt(m)), half away from zero
  function automatic longint unit_mag(logic [127:0] sq, logic [127:0] m);
    logic [255:0] rhs, lhs, odd;
    longint r, c;
    rhs = {128'b0, sq} << (2 * FB + 2);
    r = 0;
    for (int b = FB; b >= 0; b--) begin
      c = r | (64'sd1 << b);
      if (c <= (64'sd1 << FB)) begin
        odd = 256'(2 * c - 1);
        lhs = odd * odd * {128'b0, m};
        if (lhs <= rhs) r = c;
      end
    end
    return r;
  endfunction

  // four times area and unit normal of one triangle
  function automatic tri_res_t triangle_expect(tri_t t);
    longint p[9], e[3], f[3], n[3], q;
    logic [127:0] sq[3], m, h, cc;
    logic [63:0] root, c;
    tri_res_t r;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(t[i]));
    for (int i = 0; i < 3; i++) begin
      e[i] = p[3 + i] - p[i];
      f[i] = p[6 + i] - p[3 + i];
    end
    n[0] = e[1] * f[2] - e[2] * f[1];
    n[1] = e[2] * f[0] - e[0] * f[2];
    n[2] = e[0] * f[1] - e[1] * f[0];
    m = '0;
    for (int i = 0; i < 3; i++) begin
      sq[i] = {64'b0, (n[i] < 0) ? -n[i] : n[i]};
      sq[i] = sq[i] * sq[i];
      m += sq[i];
    end
    r = '0;
    if (m == 0) begin
      r.degen = 1'b1;
      return r;
    end
    h = m << 2;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (64'd1 << b);
      cc = {64'b0, c} * {64'b0, c};
      if (cc <= h) root = c;
    end
    r.area = (root > {27'b0, tan_pkg::AREA_MAX}) ? tan_pkg::AREA_MAX
                                                 : root[tan_pkg::AREA_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q = unit_mag(sq[i], m);
      if (n[i] < 0) q = -q;
      if (q > tan_pkg::NORM_MAX) q = tan_pkg::NORM_MAX;
      if (q < tan_pkg::NORM_MIN) q = tan_pkg::NORM_MIN;
      if (i == 0) r.nx = q[15:0];
      else if (i == 1) r.ny = q[15:0];
      else r.nz = q[15:0];
    end
    return r;
  endfunction

  function automatic tri_t mk_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2);
    tri_t t;
    t[0] = CW'(a0); t[1] = CW'(a1); t[2] = CW'(a2);
    t[3] = CW'(b0); t[4] = CW'(b1); t[5] = CW'(b2);
    t[6] = CW'(c0); t[7] = CW'(c1); t[8] = CW'(c2);
    return t;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // random triangle: mostly full range, some small, collinear or corner cases
  function automatic tri_t rand_tri();
    tri_t t;
    int sel, k, pb, d, base;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      base = ($urandom_range(0, 1)) ? 32767 : -32768;
      if (sel <= 4) t[i] = CW'($urandom);
      else if (sel <= 6) t[i] = CW'($urandom_range(0, 16) - 8);
      else if (sel == 8) t[i] = CW'(pick_extreme());
      else if (sel == 9) t[i] = CW'(base + int'($urandom_range(0, 64)) - 32);
    end
    if (sel == 7) begin
      k = $urandom_range(0, 10) - 5;
      for (int i = 0; i < 3; i++) begin
        pb = $urandom_range(0, 2000) - 1000;
        d = $urandom_range(0, 200) - 100;
        t[i] = CW'(pb);
        t[3 + i] = CW'(pb + d);
        t[6 + i] = CW'(pb + k * d);
      end
    end
    return t;
  endfunction

  function automatic void add_row(tri_t t, bit typed, tri_res_t r);
    stim_row_t s;
    s.corners = t;
    s.typed = typed;
    s.res = r;
    rows.push_back(s);
  endfunction

  // capture accepted items and their expected results
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && start && !busy) begin
      pending_res.push_back(triangle_expect({v2_z, v2_y, v2_x, v1_z, v1_y, v1_x,
                                             v0_z, v0_y, v0_x}));
      accepted_cnt = accepted_cnt + 1;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    tri_res_t want, got;
    if (!rst && done) begin
      got = '{area_times_four, normal_x, normal_y, normal_z, degenerate};
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        failed = 1;
      end else begin
        want = pending_res.pop_front();
        if (want.area !== got.area) begin
          $display("%0t: area_times_four expected %0d actual %0d", $time, want.area, got.area);
          failed = 1;
        end
        if (want.nx !== got.nx) begin
          $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, got.nx);
          failed = 1;
        end
        if (want.ny !== got.ny) begin
          $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, got.ny);
          failed = 1;
        end
        if (want.nz !== got.nz) begin
          $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, got.nz);
          failed = 1;
        end
        if (want.degen !== got.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degen, got.degen);
          failed = 1;
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // drive one item and hold it until taken, then idle at the given rate
  task automatic send_tri(tri_t t, int idle_pct);
    int seen;
    seen = accepted_cnt;
    start <= 1'b1;
    {v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x} <= t;
    wait (accepted_cnt != seen);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(1, 100) <= idle_pct) @(posedge clk);
    end
  endtask

  initial begin
    tri_res_t zero_res, degen_res, unit_res, got_chk;
    int idle_pct;
    zero_res = '0;
    degen_res = '0;
    degen_res.degen = 1'b1;
    unit_res = '0;
    unit_res.area = tan_pkg::AREA_W'(2);
    unit_res.nz = 16'sd16384;

    // directed table
    add_row(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, degen_res);
    add_row(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, -32768, -32768), 1, degen_res);
    add_row(mk_tri(32767, 32767, 32767, 32767, 32767, 32767,
                   32767, 32767, 32767), 1, degen_res);
    add_row(mk_tri(0, 0, 0, 1, 1, 1, 2, 2, 2), 1, degen_res);
    add_row(mk_tri(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0), 0, zero_res);
    add_row(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, unit_res);
    add_row(mk_tri(0, 0, 0, 0, 1, 0, 1, 0, 0), 0, zero_res);
    add_row(mk_tri(0, 0, 0, 0, 1, 0, 0, 0, 1), 0, zero_res);
    add_row(mk_tri(0, 0, 0, 0, 0, 1, 1, 0, 0), 0, zero_res);
    add_row(mk_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                   -32768, 32767, -32768), 0, zero_res);
    add_row(mk_tri(32767, 32767, 32767, -32768, 32767, 32767,
                   32767, -32768, -32768), 0, zero_res);
    add_row(mk_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                   -32768, -32768, 32767), 0, zero_res);
    add_row(mk_tri(0, 0, 0, 3, 0, 0, 0, 4, 4), 0, zero_res);
    add_row(mk_tri(1, 2, 3, 4, 5, 6, 7, 8, 10), 0, zero_res);
    add_row(mk_tri(-1, -1, -1, 0, 0, 0, -1, 0, -1), 0, zero_res);
    add_row(mk_tri(-32768, 0, 0, 32767, 0, 0, 32767, 1, 0), 0, zero_res);

    // typed rows must agree with the predictor too
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        got_chk = triangle_expect(rows[i].corners);
        if (got_chk !== rows[i].res) begin
          $display("%0t: directed row %0d expected %p actual %p", $time, i,
                   rows[i].res, got_chk);
          failed = 1;
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_tri(rows[i].corners, 0);

    // random phases with different sender idle rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: idle_pct = 80;
        2: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) send_tri(rand_tri(), idle_pct);
      // hold off until everything in flight has come back
      start <= 1'b0;
      @(posedge clk);
      while (pending_res.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (pending_res.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_res.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
